// ===== sv/pbfm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfm_pkg: shared definitions of the page buffer frame manager
// Request and status codes, field widths and the scan control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package pbfm_pkg;
   localparam int FRAMES_DEF = 128;
   localparam int KIND_W     = 3;
   localparam int FILE_W     = 8;
   localparam int PAGE_W     = 20;
   localparam int FIDX_W     = 7;
   localparam int STATUS_W   = 2;
   localparam int PIN_W      = 8;
   localparam int STAMP_W    = 16;
   localparam int TAG_W      = FILE_W + PAGE_W;

   localparam logic [PIN_W-1:0] PIN_MAX = 8'd255;

   localparam logic [KIND_W-1:0] KIND_GET     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UNPIN   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DISPOSE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DIRTY   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd3;

   typedef struct packed {
      logic clear;     // start of a pass
      logic step;      // entry data valid this cycle
      logic age_mode;  // 1: oldest stamp, 0: first tag match
      logic live;      // entry valid (match) or queued (age)
   } scan_ctl_type;
endpackage
`default_nettype wire

// ===== sv/pbfm_frame_store.sv =====
// ----------------------------------------------------------------------------
// pbfm_frame_store: per-frame tag, pin count and queue stamp memories
// One shared read address with registered data, one write address.
// ----------------------------------------------------------------------------
`default_nettype none
module pbfm_frame_store #(
   parameter int FRAMES = pbfm_pkg::FRAMES_DEF
) (
   input  wire logic                         clock,
   input  wire logic [$clog2(FRAMES)-1:0]    rd_addr,
   input  wire logic [$clog2(FRAMES)-1:0]    wr_addr,
   input  wire logic                         tag_we,
   input  wire logic [pbfm_pkg::TAG_W-1:0]   tag_wd,
   input  wire logic                         pin_we,
   input  wire logic [pbfm_pkg::PIN_W-1:0]   pin_wd,
   input  wire logic                         stamp_we,
   input  wire logic [pbfm_pkg::STAMP_W-1:0] stamp_wd,
   output logic      [pbfm_pkg::TAG_W-1:0]   tag_q,
   output logic      [pbfm_pkg::PIN_W-1:0]   pin_q,
   output logic      [pbfm_pkg::STAMP_W-1:0] stamp_q
);
   import pbfm_pkg::*;

   logic [TAG_W-1:0]   tag_mem   [FRAMES];
   logic [PIN_W-1:0]   pin_mem   [FRAMES];
   logic [STAMP_W-1:0] stamp_mem [FRAMES];

   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[wr_addr] <= tag_wd;
      if (pin_we) pin_mem[wr_addr] <= pin_wd;
      if (stamp_we) stamp_mem[wr_addr] <= stamp_wd;
      tag_q   <= tag_mem[rd_addr];
      pin_q   <= pin_mem[rd_addr];
      stamp_q <= stamp_mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== sv/pbfm_scan_unit.sv =====
// ----------------------------------------------------------------------------
// pbfm_scan_unit: shared compare unit for frame passes
// Finds the first frame matching a tag, or the oldest queued frame.
// ----------------------------------------------------------------------------
`default_nettype none
module pbfm_scan_unit #(
   parameter int FRAMES = pbfm_pkg::FRAMES_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pbfm_pkg::scan_ctl_type       ctl,
   input  wire logic [$clog2(FRAMES)-1:0]    idx,
   input  wire logic [pbfm_pkg::TAG_W-1:0]   tag_q,
   input  wire logic [pbfm_pkg::TAG_W-1:0]   key,
   input  wire logic [pbfm_pkg::STAMP_W-1:0] stamp_q,
   input  wire logic [pbfm_pkg::STAMP_W-1:0] stamp_now,
   output logic                              found,
   output logic      [$clog2(FRAMES)-1:0]    best_idx
);
   import pbfm_pkg::*;

   logic                      found_ff, found_in;
   logic [$clog2(FRAMES)-1:0] best_ff, best_in;
   logic [STAMP_W-1:0]        age_ff, age_in, age;
   logic                      take;

   always_comb begin
      age  = stamp_now - stamp_q;
      if (ctl.age_mode)
         take = ctl.step && ctl.live && (!found_ff || age > age_ff);
      else
         take = ctl.step && ctl.live && !found_ff && tag_q == key;
      found_in = ctl.clear ? 1'b0 : (found_ff | take);
      best_in  = take ? idx : best_ff;
      age_in   = take ? age : age_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_ff <= best_in;
      age_ff  <= age_in;
   end

   assign found    = found_ff;
   assign best_idx = best_ff;
endmodule
`default_nettype wire

// ===== sv/page_buffer_frame_manager_top.sv =====
// ----------------------------------------------------------------------------
// page_buffer_frame_manager_top: frame manager of a page buffer pool
//
// Requests arrive on req_* (valid/ready); one response per request leaves
// on rsp_* (valid/ready). A transfer on req_ is taken only while idle; the
// block then works on that request alone until its response transfer.
// Get and dispose scan all tags; a get miss or an allocate with an empty
// free ring scans all queue stamps, after the free ring check. A chosen
// frame then passes through fetch, update and the response state. Both
// scans use the single shared scan unit reading one frame per cycle from
// the frame memories.
// Unpin, flush and mark dirty of a mapped frame go straight to fetch.
// After reset all frames are unmapped, the free ring holds every frame in
// order and the victim queue is empty; no clearing pass is needed.
// A stalled rsp_ready holds the response register; req_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none
module page_buffer_frame_manager_top #(
   parameter int FRAMES = pbfm_pkg::FRAMES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [pbfm_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [pbfm_pkg::FILE_W-1:0]   req_file_id,
   input  wire logic [pbfm_pkg::PAGE_W-1:0]   req_page_number,
   input  wire logic [pbfm_pkg::FIDX_W-1:0]   req_frame_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [pbfm_pkg::STATUS_W-1:0] rsp_status,
   output logic      [pbfm_pkg::FIDX_W-1:0]   rsp_result_frame,
   output logic                               rsp_hit,
   output logic                               rsp_read_needed,
   output logic                               rsp_write_back,
   output logic      [pbfm_pkg::FILE_W-1:0]   rsp_write_back_file,
   output logic      [pbfm_pkg::PAGE_W-1:0]   rsp_write_back_page,
   output logic                               rsp_pin_overflow
);
   import pbfm_pkg::*;

   localparam int IDX_W = $clog2(FRAMES);
   localparam int CNT_W = $clog2(FRAMES + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOOK   = 4'd1;
   localparam logic [3:0] S_VICT   = 4'd2;
   localparam logic [3:0] S_RING   = 4'd3;
   localparam logic [3:0] S_AGE    = 4'd4;
   localparam logic [3:0] S_FETCH  = 4'd5;
   localparam logic [3:0] S_COMMIT = 4'd6;
   localparam logic [3:0] S_OUT    = 4'd7;

   logic [3:0]         state_ff, state_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [TAG_W-1:0]   key_ff;
   logic [IDX_W-1:0]   tgt_ff;
   logic               miss_ff;        // replacing a frame
   logic [CNT_W-1:0]   cnt_ff;
   logic               pipe_vld_ff;
   logic [IDX_W-1:0]   pipe_idx_ff;
   logic [FRAMES-1:0]  valid_ff, dirty_ff, queued_ff, ring_set_ff;
   logic [IDX_W-1:0]   head_ff;
   logic [CNT_W-1:0]   free_count_ff;
   logic [STAMP_W-1:0] stamp_ctr_ff;
   logic [IDX_W-1:0]   ring_mem [FRAMES];
   logic [IDX_W-1:0]   ring_q_ff;
   logic               ring_set_q_ff;
   logic [IDX_W-1:0]   head_q_ff;

   logic               rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [FIDX_W-1:0]  frame_out_ff;
   logic               hit_ff, read_ff, wb_ff, ovf_ff;
   logic [FILE_W-1:0]  wb_file_ff;
   logic [PAGE_W-1:0]  wb_page_ff;

   logic               accept, scanning, scan_done, fi_ok;
   logic [IDX_W-1:0]   fi_idx, rd_addr, best_idx, ring_v;
   logic [TAG_W-1:0]   tag_q;
   logic [PIN_W-1:0]   pin_q;
   logic [STAMP_W-1:0] stamp_q;
   logic               found;
   scan_ctl_type       sctl;
   logic [CNT_W:0]     tail_sum;
   logic [IDX_W-1:0]   tail;
   logic               tag_we, pin_we, stamp_we;
   logic [PIN_W-1:0]   pin_wd;
   logic               hit_path;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign scanning  = (state_ff == S_LOOK) || (state_ff == S_AGE);
   assign scan_done = scanning && (cnt_ff == CNT_W'(FRAMES)) && !pipe_vld_ff;
   assign fi_idx    = IDX_W'(req_frame_index);
   assign fi_ok     = (32'(req_frame_index) < FRAMES) && valid_ff[fi_idx];
   assign rd_addr   = scanning ? cnt_ff[IDX_W-1:0] : tgt_ff;
   assign ring_v    = ring_set_q_ff ? ring_q_ff : head_q_ff;
   assign hit_path  = (kind_ff == KIND_GET) && !miss_ff;

   // free ring tail = (head + count) mod FRAMES, sum below 2*FRAMES
   always_comb begin
      tail_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(free_count_ff);
      if (tail_sum >= (CNT_W+1)'(FRAMES))
         tail = IDX_W'(tail_sum - (CNT_W+1)'(FRAMES));
      else
         tail = IDX_W'(tail_sum);
   end

   always_comb begin
      sctl.clear    = accept || (state_ff == S_VICT);
      sctl.step     = scanning && pipe_vld_ff;
      sctl.age_mode = (state_ff == S_AGE);
      sctl.live     = sctl.age_mode ? queued_ff[pipe_idx_ff] : valid_ff[pipe_idx_ff];
   end

   // memory writes of the commit step
   always_comb begin
      tag_we   = (state_ff == S_COMMIT) && miss_ff;
      pin_we   = 1'b0;
      pin_wd   = '0;
      stamp_we = 1'b0;
      if (state_ff == S_COMMIT) begin
         if (miss_ff) begin
            pin_we = 1'b1;
            pin_wd = PIN_W'(1);
         end else if (hit_path && pin_q != PIN_MAX) begin
            pin_we = 1'b1;
            pin_wd = pin_q + PIN_W'(1);
         end else if (kind_ff == KIND_UNPIN && pin_q != '0) begin
            pin_we   = 1'b1;
            pin_wd   = pin_q - PIN_W'(1);
            stamp_we = (pin_q == PIN_W'(1));
         end
      end
   end

   pbfm_frame_store #(.FRAMES(FRAMES)) u_store (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .wr_addr  (tgt_ff),
      .tag_we   (tag_we),
      .tag_wd   (key_ff),
      .pin_we   (pin_we),
      .pin_wd   (pin_wd),
      .stamp_we (stamp_we),
      .stamp_wd (stamp_ctr_ff),
      .tag_q    (tag_q),
      .pin_q    (pin_q),
      .stamp_q  (stamp_q)
   );

   pbfm_scan_unit #(.FRAMES(FRAMES)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sctl),
      .idx       (pipe_idx_ff),
      .tag_q     (tag_q),
      .key       (key_ff),
      .stamp_q   (stamp_q),
      .stamp_now (stamp_ctr_ff),
      .found     (found),
      .best_idx  (best_idx)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_GET, KIND_DISPOSE:           state_in = S_LOOK;
                  KIND_ALLOC:                       state_in = S_VICT;
                  KIND_UNPIN, KIND_FLUSH, KIND_DIRTY:
                     state_in = fi_ok ? S_FETCH : S_OUT;
                  default:                          state_in = S_OUT;
               endcase
            end
         end
         S_LOOK: begin
            if (scan_done) begin
               if (found) state_in = S_FETCH;
               else if (kind_ff == KIND_GET) state_in = S_VICT;
               else state_in = S_OUT;
            end
         end
         S_VICT:   state_in = (free_count_ff != '0) ? S_RING : S_AGE;
         S_RING:   state_in = S_FETCH;
         S_AGE:    if (scan_done) state_in = found ? S_FETCH : S_OUT;
         S_FETCH:  state_in = S_COMMIT;
         S_COMMIT: state_in = S_OUT;
         S_OUT:    if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         dirty_ff      <= '0;
         queued_ff     <= '0;
         ring_set_ff   <= '0;
         head_ff       <= '0;
         free_count_ff <= CNT_W'(FRAMES);
         stamp_ctr_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         pipe_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= scanning && (cnt_ff != CNT_W'(FRAMES));
         if (accept || state_ff == S_VICT) begin
            cnt_ff <= '0;
         end else if (scanning && cnt_ff != CNT_W'(FRAMES)) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (state_ff == S_RING) begin
            head_ff       <= (32'(head_ff) == FRAMES - 1) ? '0 : head_ff + IDX_W'(1);
            free_count_ff <= free_count_ff - CNT_W'(1);
         end
         if (state_ff == S_COMMIT) begin
            if (miss_ff) begin
               valid_ff[tgt_ff]  <= 1'b1;
               dirty_ff[tgt_ff]  <= 1'b0;
               queued_ff[tgt_ff] <= 1'b0;
            end else begin
               case (kind_ff)
                  KIND_GET:   queued_ff[tgt_ff] <= 1'b0;
                  KIND_UNPIN: begin
                     if (pin_q == PIN_W'(1)) begin
                        queued_ff[tgt_ff] <= 1'b1;
                        stamp_ctr_ff      <= stamp_ctr_ff + STAMP_W'(1);
                     end
                  end
                  KIND_FLUSH: dirty_ff[tgt_ff] <= 1'b0;
                  KIND_DIRTY: dirty_ff[tgt_ff] <= 1'b1;
                  KIND_DISPOSE: begin
                     valid_ff[tgt_ff]  <= 1'b0;
                     dirty_ff[tgt_ff]  <= 1'b0;
                     queued_ff[tgt_ff] <= 1'b0;
                     if (free_count_ff < CNT_W'(FRAMES)) begin
                        ring_set_ff[tail] <= 1'b1;
                        free_count_ff     <= free_count_ff + CNT_W'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         if (state_ff == S_COMMIT || (state_ff == S_IDLE && state_in == S_OUT) ||
             ((state_ff == S_LOOK || state_ff == S_AGE) && state_in == S_OUT)) begin
            rsp_valid_ff <= 1'b1;
         end else if (state_ff == S_OUT && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // free ring memory
   always_ff @(posedge clock) begin
      if (state_ff == S_COMMIT && !miss_ff && kind_ff == KIND_DISPOSE &&
          free_count_ff < CNT_W'(FRAMES)) begin
         ring_mem[tail] <= tgt_ff;
      end
      ring_q_ff     <= ring_mem[head_ff];
      ring_set_q_ff <= ring_set_ff[head_ff];
      head_q_ff     <= head_ff;
   end

   // request and response payload
   always_ff @(posedge clock) begin
      pipe_idx_ff <= cnt_ff[IDX_W-1:0];
      if (accept) begin
         kind_ff      <= req_kind;
         key_ff       <= {req_file_id, req_page_number};
         tgt_ff       <= fi_idx;
         miss_ff      <= (req_kind == KIND_ALLOC);
         status_ff    <= (req_kind == KIND_UNPIN || req_kind == KIND_FLUSH ||
                          req_kind == KIND_DIRTY) && !fi_ok ? ST_UNMAPPED : ST_OK;
         frame_out_ff <= '0;
         hit_ff       <= 1'b0;
         read_ff      <= 1'b0;
         wb_ff        <= 1'b0;
         wb_file_ff   <= '0;
         wb_page_ff   <= '0;
         ovf_ff       <= 1'b0;
      end
      if (state_ff == S_LOOK && scan_done) begin
         if (found) tgt_ff <= best_idx;
         else if (kind_ff == KIND_GET) miss_ff <= 1'b1;
         else status_ff <= ST_ABSENT;
      end
      if (state_ff == S_RING) tgt_ff <= ring_v;
      if (state_ff == S_AGE && scan_done) begin
         if (found) tgt_ff <= best_idx;
         else status_ff <= ST_NO_FRAME;
      end
      if (state_ff == S_COMMIT) begin
         if (miss_ff) begin
            frame_out_ff <= FIDX_W'(tgt_ff);
            read_ff      <= (kind_ff == KIND_GET);
            if (valid_ff[tgt_ff] && dirty_ff[tgt_ff]) begin
               wb_ff      <= 1'b1;
               wb_file_ff <= tag_q[TAG_W-1:PAGE_W];
               wb_page_ff <= tag_q[PAGE_W-1:0];
            end
         end else begin
            case (kind_ff)
               KIND_GET: begin
                  frame_out_ff <= FIDX_W'(tgt_ff);
                  hit_ff       <= 1'b1;
                  ovf_ff       <= (pin_q == PIN_MAX);
               end
               KIND_UNPIN: ovf_ff <= (pin_q == '0);
               KIND_FLUSH, KIND_DISPOSE: begin
                  if (kind_ff == KIND_FLUSH || dirty_ff[tgt_ff]) begin
                     wb_ff      <= 1'b1;
                     wb_file_ff <= tag_q[TAG_W-1:PAGE_W];
                     wb_page_ff <= tag_q[PAGE_W-1:0];
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_result_frame    = frame_out_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_read_needed     = read_ff;
   assign rsp_write_back      = wb_ff;
   assign rsp_write_back_file = wb_file_ff;
   assign rsp_write_back_page = wb_page_ff;
   assign rsp_pin_overflow    = ovf_ff;

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff) else $error("request taken while response pending");
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(FRAMES)) else $error("free count above frame total");
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready) else $error("ready right after a transfer");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> rsp_valid_ff) else $error("response state without valid");
endmodule
`default_nettype wire
